// File: rtl/receive_buffer_reassembler_assert.svh
`ifndef RECEIVE_BUFFER_REASSEMBLER_ASSERT_SVH
`define RECEIVE_BUFFER_REASSEMBLER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define RBR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define RBR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rbr_pkg.sv
package rbr_pkg;

    // Field widths
    localparam int FUNC_W  = 2;
    localparam int CIN_W   = 14;
    localparam int BUF_W   = 4;
    localparam int WANT_W  = 20;
    localparam int OFF_W   = 12;
    localparam int LEN_W   = 13;
    localparam int ERR_W   = 12;
    localparam int CNT_W   = 13;
    localparam int MEM_W   = BUF_W + CNT_W;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    // Largest positive arrival count the input field can carry
    localparam int CNT_MAX = 8191;

    localparam int MAX_SEGS = 16;
    localparam int SEG_W    = 4;
    localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(MAX_SEGS - 1);

    localparam logic [ERR_W-1:0] EPIPE   = ERR_W'(32);
    localparam logic [ERR_W-1:0] ERR_MAX = ERR_W'(4095);

    // Item selector codes
    localparam logic [FUNC_W-1:0] FN_ARRIVE  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REQUEST = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CLOSE   = 2'd2;

    typedef struct packed {
        logic take_item;
        logic apply_arrival;
        logic apply_close;
        logic start_ext;
        logic clear_parked;
        logic set_parked;
        logic emit_seg;
        logic emit_err;
    } t_cmd;

    typedef struct packed {
        logic is_arrive;
        logic is_request;
        logic is_close;
        logic closed;
        logic parked;
        logic can_ext;
        logic can_err;
        logic slot_free;
        logic seg_last;
    } t_status;

endpackage

// File: rtl/receive_buffer_reassembler.sv
// Receive buffer reassembler.
// Slave stream (i_s_*): one word per event; tuser selects arrival, byte request or close.
// Arrivals queue filled buffers (number, byte count); a request for N bytes is answered
// on the master stream (o_m_*) as scatter segments from the queue front, or as an error
// report (tuser = 1) once a terminal error is latched and nothing is left to drain.
// tlast marks the final word answering a request; a request that cannot be served yet
// is parked and retried after each arrival taken while the stream is not closed.
// Timing: one item at a time. An arrival or close is applied in the execute state.
// A request is decided in the check state that follows the execute state (and parks
// there when it cannot be served), then each segment takes a load state (queue memory
// read) and an emit state (segment compute into the output register), at most 16
// segments; an error report is written from the error state.
// An arrival that retries a parked request adds the same request steps.
// The output register holds one word; while the receiver stalls, emission waits and
// no new input word is taken until the current request is answered in full.
// Reset (synchronous, active low) empties the queue, clears the parked request, the
// latched error and the closed flag; queue memory contents are not cleared.
module receive_buffer_reassembler #(
    parameter int BUFFERS      = 16,
    parameter int BUFFER_BYTES = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // arrival_count[13:0], has_buffer[14], buffer_number[18:15], want_bytes[38:19]
    input  logic [rbr_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // func[1:0]
    input  logic [rbr_pkg::FUNC_W-1:0]         i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // seg_buffer[3:0], seg_offset[15:4], seg_length[28:16], buffer_done[29],
    // error_code[41:30]
    output logic [rbr_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // kind[0]
    output logic                               o_m_tuser,
    output logic                               o_m_tlast
);
    import rbr_pkg::*;

    t_cmd    cmd;
    t_status sts;

    logic [BUF_W-1:0] seg_buffer;
    logic [OFF_W-1:0] seg_offset;
    logic [LEN_W-1:0] seg_length;
    logic             buffer_done;
    logic [ERR_W-1:0] error_code;

    rbr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rbr_datapath #(
        .BUFFERS      (BUFFERS),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_func          (i_s_tuser),
        .i_arrival_count (i_s_tdata[13:0]),
        .i_has_buffer    (i_s_tdata[14]),
        .i_buffer_number (i_s_tdata[18:15]),
        .i_want_bytes    (i_s_tdata[38:19]),
        .i_out_ready     (i_m_tready),
        .o_out_valid     (o_m_tvalid),
        .o_kind          (o_m_tuser),
        .o_seg_buffer    (seg_buffer),
        .o_seg_offset    (seg_offset),
        .o_seg_length    (seg_length),
        .o_buffer_done   (buffer_done),
        .o_error_code    (error_code),
        .o_last          (o_m_tlast)
    );

    assign o_m_tdata = {6'b000000, error_code, buffer_done, seg_length, seg_offset, seg_buffer};

    `include "receive_buffer_reassembler_assert.svh"

    `RBR_ASSERT_IMP(a_emit_into_free_slot, cmd.emit_seg || cmd.emit_err, !o_m_tvalid || i_m_tready, "emission overwrote a waiting word")
    `RBR_ASSERT_IMP(a_error_report_empty, o_m_tvalid && o_m_tuser, (o_m_tdata[29:0] == 30'd0) && o_m_tlast, "error report carries segment data")
    `RBR_ASSERT_NXT(a_busy_after_accept, i_s_tvalid && o_s_tready, !o_s_tready, "input taken while an item is in work")

endmodule

// File: rtl/rbr_ctrl.sv
module rbr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rbr_pkg::t_status i_sts,
    output rbr_pkg::t_cmd    o_cmd
);
    import rbr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_CHECK = 6'b000100,
        S_LOAD  = 6'b001000,
        S_EMIT  = 6'b010000,
        S_ERR   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready         = 1'b1;
                o_cmd.take_item = i_valid;
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_arrive) begin
                    if (i_sts.closed) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.apply_arrival = 1'b1;
                        n_state = i_sts.parked ? S_CHECK : S_IDLE;
                    end
                end else if (i_sts.is_request) begin
                    n_state = S_CHECK;
                end else if (i_sts.is_close) begin
                    o_cmd.apply_close = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CHECK: begin
                if (i_sts.can_ext) begin
                    o_cmd.start_ext    = 1'b1;
                    o_cmd.clear_parked = 1'b1;
                    n_state = S_LOAD;
                end else if (i_sts.can_err) begin
                    o_cmd.clear_parked = 1'b1;
                    n_state = S_ERR;
                end else begin
                    // park a request that cannot be served yet
                    o_cmd.set_parked = i_sts.is_request;
                    n_state = S_IDLE;
                end
            end
            S_LOAD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit_seg = 1'b1;
                    n_state = i_sts.seg_last ? S_IDLE : S_LOAD;
                end
            end
            S_ERR: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit_err = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/rbr_datapath.sv
module rbr_datapath #(
    parameter int BUFFERS      = 16,
    parameter int BUFFER_BYTES = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rbr_pkg::t_cmd                     i_cmd,
    output rbr_pkg::t_status                  o_sts,
    input  logic [rbr_pkg::FUNC_W-1:0]        i_func,
    input  logic signed [rbr_pkg::CIN_W-1:0]  i_arrival_count,
    input  logic                              i_has_buffer,
    input  logic [rbr_pkg::BUF_W-1:0]         i_buffer_number,
    input  logic [rbr_pkg::WANT_W-1:0]        i_want_bytes,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_kind,
    output logic [rbr_pkg::BUF_W-1:0]         o_seg_buffer,
    output logic [rbr_pkg::OFF_W-1:0]         o_seg_offset,
    output logic [rbr_pkg::LEN_W-1:0]         o_seg_length,
    output logic                              o_buffer_done,
    output logic [rbr_pkg::ERR_W-1:0]         o_error_code,
    output logic                              o_last
);
    import rbr_pkg::*;

    localparam int SAT_BYTES = (BUFFER_BYTES < CNT_MAX) ? BUFFER_BYTES : CNT_MAX;
    localparam int IDX_W     = $clog2(BUFFERS);
    localparam int FILL_W    = $clog2(BUFFERS + 1);
    localparam int PEND_W    = $clog2(BUFFERS * SAT_BYTES + 1);
    localparam int CMP_W     = (PEND_W > WANT_W) ? PEND_W : WANT_W;

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(BUFFERS - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(BUFFERS);
    localparam logic [CNT_W-1:0]  SAT_CNT   = CNT_W'(SAT_BYTES);

    // Queue memory: buffer number above byte count
    logic [MEM_W-1:0] mem [BUFFERS];
    logic [MEM_W-1:0] r_rd;

    // Captured item
    logic [FUNC_W-1:0]       r_func;
    logic signed [CIN_W-1:0] r_count;
    logic                    r_has_buf;
    logic [BUF_W-1:0]        r_bufnum;
    logic [WANT_W-1:0]       r_want;

    // Reassembly state
    logic [IDX_W-1:0]  r_head;
    logic [IDX_W-1:0]  r_tail;
    logic [FILL_W-1:0] r_fill;
    logic [CNT_W-1:0]  r_front;
    logic [PEND_W-1:0] r_pend;
    logic              r_parked;
    logic [WANT_W-1:0] r_parked_want;
    logic              r_term;
    logic [ERR_W-1:0]  r_errno;
    logic              r_closed;
    logic [WANT_W-1:0] r_remain;
    logic [SEG_W-1:0]  r_seg_idx;

    // Output register
    logic              r_out_valid;
    logic              r_kind;
    logic [BUF_W-1:0]  r_seg_buffer;
    logic [OFF_W-1:0]  r_seg_offset;
    logic [LEN_W-1:0]  r_seg_length;
    logic              r_buffer_done;
    logic [ERR_W-1:0]  r_error_code;
    logic              r_last;

    logic              pos;
    logic [CNT_W-1:0]  cnt_mag;
    logic [CNT_W-1:0]  cnt_sat;
    logic              push;
    logic [CIN_W-1:0]  neg_mag;
    logic [ERR_W-1:0]  err_new;
    logic              latch;
    logic [WANT_W-1:0] want_sel;
    logic [CMP_W-1:0]  pend_ext;
    logic [CMP_W-1:0]  want_ext;
    logic [WANT_W-1:0] drain;
    logic              can_ext;
    logic [BUF_W-1:0]  rd_buf;
    logic [CNT_W-1:0]  rd_cnt;
    logic [CNT_W-1:0]  avail;
    logic              seg_done;
    logic [CNT_W-1:0]  seg_len;
    logic [WANT_W-1:0] remain_next;
    logic              seg_last;
    logic              slot_free;
    logic [IDX_W-1:0]  head_inc;
    logic [IDX_W-1:0]  tail_inc;

    // Arrival decode
    assign pos     = !r_count[CIN_W-1] && (r_count != '0);
    assign cnt_mag = r_count[CNT_W-1:0];
    assign cnt_sat = (cnt_mag > SAT_CNT) ? SAT_CNT : cnt_mag;
    assign push    = pos && r_has_buf && (r_fill != FULL_FILL);
    assign neg_mag = -r_count;
    assign err_new = (r_count == '0) ? EPIPE :
                     ((neg_mag > {2'b00, ERR_MAX}) ? ERR_MAX : neg_mag[ERR_W-1:0]);
    assign latch   = !pos && !r_term;

    // Serve decision
    assign want_sel = (r_func == FN_REQUEST) ? r_want : r_parked_want;
    assign pend_ext = CMP_W'(r_pend);
    assign want_ext = CMP_W'(want_sel);
    assign drain    = (pend_ext < want_ext) ? pend_ext[WANT_W-1:0] : want_sel;
    assign can_ext  = ((want_sel != '0) && (pend_ext >= want_ext))
                    || (r_term && (drain != '0));

    // Segment at the queue front
    assign rd_buf      = r_rd[MEM_W-1:CNT_W];
    assign rd_cnt      = r_rd[CNT_W-1:0];
    assign avail       = rd_cnt - r_front;
    assign seg_done    = WANT_W'(avail) <= r_remain;
    assign seg_len     = seg_done ? avail : r_remain[CNT_W-1:0];
    assign remain_next = r_remain - WANT_W'(seg_len);
    assign seg_last    = (remain_next == '0) || (r_seg_idx == SEG_LAST);
    assign slot_free   = !r_out_valid || i_out_ready;

    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;

    always_comb begin
        o_sts            = '0;
        o_sts.is_arrive  = (r_func == FN_ARRIVE);
        o_sts.is_request = (r_func == FN_REQUEST);
        o_sts.is_close   = (r_func == FN_CLOSE);
        o_sts.closed     = r_closed;
        o_sts.parked     = r_parked;
        o_sts.can_ext    = can_ext;
        o_sts.can_err    = !can_ext && r_term;
        o_sts.slot_free  = slot_free;
        o_sts.seg_last   = seg_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply_arrival && push) begin
            mem[r_tail] <= {r_bufnum, cnt_sat};
        end
        r_rd <= mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_tail        <= '0;
            r_fill        <= '0;
            r_front       <= '0;
            r_pend        <= '0;
            r_parked      <= 1'b0;
            r_parked_want <= '0;
            r_term        <= 1'b0;
            r_errno       <= '0;
            r_closed      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.apply_arrival) begin
                if (push) begin
                    r_tail <= tail_inc;
                    r_fill <= r_fill + 1'b1;
                    r_pend <= r_pend + PEND_W'(cnt_sat);
                end
                if (latch) begin
                    r_term  <= 1'b1;
                    r_errno <= err_new;
                end
            end
            if (i_cmd.apply_close) begin
                r_closed <= 1'b1;
            end
            if (i_cmd.clear_parked) begin
                r_parked <= 1'b0;
            end
            if (i_cmd.set_parked) begin
                r_parked      <= 1'b1;
                r_parked_want <= r_want;
            end
            if (i_cmd.emit_seg) begin
                r_pend <= r_pend - PEND_W'(seg_len);
                if (seg_done) begin
                    // buffer used up: pop it
                    r_front <= '0;
                    r_head  <= head_inc;
                    r_fill  <= r_fill - 1'b1;
                end else begin
                    r_front <= r_front + seg_len;
                end
            end
            if (i_cmd.emit_seg || i_cmd.emit_err) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_func    <= i_func;
            r_count   <= i_arrival_count;
            r_has_buf <= i_has_buffer;
            r_bufnum  <= i_buffer_number;
            r_want    <= i_want_bytes;
        end
        if (i_cmd.start_ext) begin
            r_remain  <= drain;
            r_seg_idx <= '0;
        end
        if (i_cmd.emit_seg) begin
            r_remain      <= remain_next;
            r_seg_idx     <= r_seg_idx + 1'b1;
            r_kind        <= 1'b0;
            r_seg_buffer  <= rd_buf;
            r_seg_offset  <= r_front[OFF_W-1:0];
            r_seg_length  <= seg_len;
            r_buffer_done <= seg_done;
            r_error_code  <= '0;
            r_last        <= seg_last;
        end
        if (i_cmd.emit_err) begin
            r_kind        <= 1'b1;
            r_seg_buffer  <= '0;
            r_seg_offset  <= '0;
            r_seg_length  <= '0;
            r_buffer_done <= 1'b0;
            r_error_code  <= r_errno;
            r_last        <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_seg_buffer  = r_seg_buffer;
    assign o_seg_offset  = r_seg_offset;
    assign o_seg_length  = r_seg_length;
    assign o_buffer_done = r_buffer_done;
    assign o_error_code  = r_error_code;
    assign o_last        = r_last;

endmodule
